[sv/tower_to_card_fanout_index_macros.svh]
// assertion helpers for the fan-out index block
`ifndef TOWER_TO_CARD_FANOUT_INDEX_MACROS_SVH
`define TOWER_TO_CARD_FANOUT_INDEX_MACROS_SVH

// same-cycle implication
`define TCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tcf_pkg.sv]
package tcf_pkg;

    localparam int ETA_CARDS_MAX = 8;
    localparam int PHI_CARDS_MAX = 8;

    localparam int SLOT_W     = 7;
    localparam int BOUNDS_W   = 56;
    localparam int COUNT_W    = 4;
    localparam int CARD_W     = 3;
    localparam int INDEX_W    = 6;
    localparam int OPER_W     = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int ETA_LOW    = -32;
    localparam int ETA_HIGH   = 32;
    localparam int PHI_TOWERS = 72;

    localparam logic [CFG_IDX_W-1:0] REG_ETA_BOUNDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_BOUNDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_COUNT  = 2'd3;

    typedef struct packed {
        logic signed [SLOT_W-1:0] tower_eta;
        logic [SLOT_W-1:0]        tower_phi;
    } tcf_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] card_index;
        logic               last;
        logic               bad_input;
    } tcf_out_t;

    typedef struct packed {
        logic              bad;
        logic              eta_edge;
        logic              phi_edge;
        logic [CARD_W-1:0] ec;
        logic [CARD_W-1:0] ec_nb;
        logic [CARD_W-1:0] pc;
        logic [CARD_W-1:0] pc_nb;
    } tcf_job_t;

    typedef struct packed {
        logic ge;
        logic eq;
        logic eq_next;
    } tcf_cmp_t;

endpackage

[sv/tcf_cmp.sv]
module tcf_cmp (
    input  logic signed [tcf_pkg::OPER_W-1:0] coord,
    input  logic signed [tcf_pkg::OPER_W-1:0] bound,
    output tcf_pkg::tcf_cmp_t                 flags
);
    import tcf_pkg::*;

    logic signed [OPER_W-1:0] bound_inc;

    assign bound_inc     = bound + OPER_W'(1);
    assign flags.ge      = (bound >= coord);
    assign flags.eq      = (bound == coord);
    assign flags.eq_next = (coord == bound_inc);

endmodule

[sv/tcf_emit.sv]
module tcf_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  tcf_pkg::tcf_job_t             job,
    input  logic [tcf_pkg::COUNT_W-1:0]   phi_cards,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcf_pkg::tcf_out_t             out_data
);
    import tcf_pkg::*;

    localparam logic [1:0] ENTRY_HOME = 2'd0;
    localparam logic [1:0] ENTRY_ETA  = 2'd1;
    localparam logic [1:0] ENTRY_PHI  = 2'd2;
    localparam logic [1:0] ENTRY_DIAG = 2'd3;
    localparam int         WIDE_W     = INDEX_W + 1;

    logic              valid_reg;
    logic              valid_next;
    logic [1:0]        entry_reg;
    logic [1:0]        entry_next;
    tcf_job_t          job_reg;
    tcf_out_t          data_reg;

    tcf_job_t          src_job;
    logic [1:0]        sel_entry;
    logic [1:0]        adv_entry;
    logic [CARD_W-1:0] ce;
    logic [CARD_W-1:0] cp;
    logic [WIDE_W-1:0] index_wide;
    logic              sel_last;
    tcf_out_t          built;
    logic              beat_done;

    assign beat_done = valid_reg && out_ready;

    // next present entry after the current one
    always_comb
    begin
        case (entry_reg)
            ENTRY_HOME: adv_entry = job_reg.eta_edge ? ENTRY_ETA : ENTRY_PHI;
            ENTRY_ETA:  adv_entry = ENTRY_PHI;
            default:    adv_entry = ENTRY_DIAG;
        endcase
    end

    assign src_job   = start ? job : job_reg;
    assign sel_entry = start ? ENTRY_HOME : adv_entry;

    always_comb
    begin
        ce = (sel_entry == ENTRY_ETA || sel_entry == ENTRY_DIAG) ? src_job.ec_nb : src_job.ec;
        cp = (sel_entry == ENTRY_PHI || sel_entry == ENTRY_DIAG) ? src_job.pc_nb : src_job.pc;
        case (sel_entry)
            ENTRY_HOME: sel_last = !(src_job.eta_edge || src_job.phi_edge);
            ENTRY_ETA:  sel_last = !src_job.phi_edge;
            ENTRY_PHI:  sel_last = !src_job.eta_edge;
            default:    sel_last = 1'b1;
        endcase
    end

    assign index_wide = WIDE_W'(ce) * WIDE_W'(phi_cards) + WIDE_W'(cp);

    always_comb
    begin
        if (src_job.bad)
        begin
            built.card_index = '0;
            built.last       = 1'b1;
            built.bad_input  = 1'b1;
        end
        else
        begin
            built.card_index = index_wide[INDEX_W-1:0];
            built.last       = sel_last;
            built.bad_input  = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (start)
        begin
            valid_next = 1'b1;
            entry_next = ENTRY_HOME;
        end
        else if (beat_done)
        begin
            if (data_reg.last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                entry_next = adv_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            entry_reg <= ENTRY_HOME;
        end
        else
        begin
            valid_reg <= valid_next;
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg  <= job;
            data_reg <= built;
        end
        else if (beat_done && !data_reg.last)
        begin
            data_reg <= built;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/tower_to_card_fanout_index.sv]
// Places one calorimeter tower (eta, phi) on its home card and lists the
// neighbour cards that share its edge: home first, then the eta neighbour,
// the phi neighbour and the diagonal, one beat each, last set on the final
// beat. A bad coordinate, or an eta above every used eta bound, gives a
// single beat with bad_input set and card_index 0. A sequencer walks the
// bound slots one per cycle through a single shared compare unit, so a
// tower occupies the input side for one step per eta slot searched, one
// per phi slot searched, and one for each edge test, and longer while
// beats of the previous tower still wait on the output.
// An invalid coordinate skips the search. The 1 to 4 result beats leave from
// an output register while the next tower is already being searched.
// Configuration writes are taken at any time and must be made while idle.
`include "tower_to_card_fanout_index_macros.svh"

module tower_to_card_fanout_index #(
    parameter int MAX_ETA_CARDS = tcf_pkg::ETA_CARDS_MAX,
    parameter int MAX_PHI_CARDS = tcf_pkg::PHI_CARDS_MAX
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tcf_pkg::tcf_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tcf_pkg::tcf_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcf_pkg::BOUNDS_W-1:0]    cfg_data
);
    import tcf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ETA   = 4'd1;
    localparam logic [3:0] S_PLAST = 4'd2;
    localparam logic [3:0] S_PHI   = 4'd3;
    localparam logic [3:0] S_EUP   = 4'd4;
    localparam logic [3:0] S_ELO   = 4'd5;
    localparam logic [3:0] S_PUP   = 4'd6;
    localparam logic [3:0] S_PLO   = 4'd7;
    localparam logic [3:0] S_PWRAP = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [BOUNDS_W-1:0]      eta_bounds_reg;
    logic [BOUNDS_W-1:0]      phi_bounds_reg;
    logic [COUNT_W-1:0]       eta_count_reg;
    logic [COUNT_W-1:0]       phi_count_reg;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic [CARD_W-1:0]        idx_reg;
    logic [CARD_W-1:0]        idx_next;
    logic signed [SLOT_W-1:0] eta_reg;
    logic signed [SLOT_W-1:0] eta_next;
    logic [SLOT_W-1:0]        phi_reg;
    logic [SLOT_W-1:0]        phi_next;
    logic [SLOT_W-1:0]        plast_reg;
    logic [SLOT_W-1:0]        plast_next;
    tcf_job_t                 job_reg;
    tcf_job_t                 job_next;

    logic [COUNT_W-1:0]       ne;
    logic [COUNT_W-1:0]       np;
    logic [CARD_W-1:0]        ne_last;
    logic [CARD_W-1:0]        np_last;
    logic [SLOT_W-1:0]        eta_slot;
    logic [SLOT_W-1:0]        phi_slot;
    logic [SLOT_W-1:0]        plast_mod;
    logic                     eta_phase;
    logic signed [OPER_W-1:0] cmp_coord;
    logic signed [OPER_W-1:0] cmp_bound;
    tcf_cmp_t                 cmp;
    logic                     in_beat;
    logic                     in_bad;
    logic                     emit_start;
    logic [COUNT_W-1:0]       pc_inc;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_bounds_reg <= BOUNDS_W'(ETA_HIGH);
            phi_bounds_reg <= BOUNDS_W'(PHI_TOWERS);
            eta_count_reg  <= COUNT_W'(1);
            phi_count_reg  <= COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ETA_BOUNDS: eta_bounds_reg <= cfg_data;
                REG_PHI_BOUNDS: phi_bounds_reg <= cfg_data;
                REG_ETA_COUNT:  eta_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_PHI_COUNT:  phi_count_reg  <= cfg_data[COUNT_W-1:0];
                default:        eta_count_reg  <= eta_count_reg;
            endcase
        end
    end

    // used card counts
    assign ne = (eta_count_reg == '0) ? COUNT_W'(1) :
                (eta_count_reg > COUNT_W'(MAX_ETA_CARDS)) ? COUNT_W'(MAX_ETA_CARDS) :
                eta_count_reg;
    assign np = (phi_count_reg == '0) ? COUNT_W'(1) :
                (phi_count_reg > COUNT_W'(MAX_PHI_CARDS)) ? COUNT_W'(MAX_PHI_CARDS) :
                phi_count_reg;
    assign ne_last = CARD_W'(ne - COUNT_W'(1));
    assign np_last = CARD_W'(np - COUNT_W'(1));

    // shared compare operands
    assign eta_slot  = eta_bounds_reg[SLOT_W*idx_reg +: SLOT_W];
    assign phi_slot  = phi_bounds_reg[SLOT_W*idx_reg +: SLOT_W];
    assign plast_mod = (plast_reg >= SLOT_W'(PHI_TOWERS)) ? plast_reg - SLOT_W'(PHI_TOWERS)
                                                         : plast_reg;
    assign eta_phase = (state_reg == S_ETA) || (state_reg == S_EUP) || (state_reg == S_ELO);

    always_comb
    begin
        if (eta_phase)
        begin
            cmp_coord = OPER_W'(eta_reg);
            cmp_bound = OPER_W'($signed(eta_slot));
        end
        else if (state_reg == S_PWRAP)
        begin
            cmp_coord = $signed(OPER_W'(phi_reg));
            cmp_bound = $signed(OPER_W'(plast_mod));
        end
        else
        begin
            cmp_coord = $signed(OPER_W'(phi_reg));
            cmp_bound = $signed(OPER_W'(phi_slot));
        end
    end

    tcf_cmp u_cmp (
        .coord (cmp_coord),
        .bound (cmp_bound),
        .flags (cmp)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_beat    = in_valid && in_ready;
    assign in_bad     = (in_data.tower_eta < ETA_LOW) || (in_data.tower_eta > ETA_HIGH) ||
                        (in_data.tower_eta == '0) || (in_data.tower_phi == '0) ||
                        (in_data.tower_phi > SLOT_W'(PHI_TOWERS));
    assign emit_start = (state_reg == S_WAIT) && !out_valid;
    assign pc_inc     = COUNT_W'(job_reg.pc) + COUNT_W'(1);

    // search sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        eta_next   = eta_reg;
        phi_next   = phi_reg;
        plast_next = plast_reg;
        job_next   = job_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    eta_next = in_data.tower_eta;
                    phi_next = in_data.tower_phi;
                    job_next = '0;
                    idx_next = '0;
                    if (in_bad)
                    begin
                        job_next.bad = 1'b1;
                        state_next   = S_WAIT;
                    end
                    else
                    begin
                        state_next = S_ETA;
                    end
                end
            end
            S_ETA:
            begin
                if (cmp.ge)
                begin
                    job_next.ec = idx_reg;
                    idx_next    = np_last;
                    state_next  = S_PLAST;
                end
                else if (idx_reg == ne_last)
                begin
                    job_next.bad = 1'b1;
                    state_next   = S_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + CARD_W'(1);
                end
            end
            S_PLAST:
            begin
                plast_next = phi_slot;
                if (cmp.ge)
                begin
                    idx_next   = '0;
                    state_next = S_PHI;
                end
                else
                begin
                    job_next.pc = '0;
                    idx_next    = job_reg.ec;
                    state_next  = S_EUP;
                end
            end
            S_PHI:
            begin
                if (cmp.ge || idx_reg == np_last)
                begin
                    job_next.pc = cmp.ge ? idx_reg : '0;
                    idx_next    = job_reg.ec;
                    state_next  = S_EUP;
                end
                else
                begin
                    idx_next = idx_reg + CARD_W'(1);
                end
            end
            S_EUP:
            begin
                if (job_reg.ec != ne_last && cmp.eq)
                begin
                    job_next.eta_edge = 1'b1;
                    job_next.ec_nb    = job_reg.ec + CARD_W'(1);
                    idx_next          = job_reg.pc;
                    state_next        = S_PUP;
                end
                else if (job_reg.ec != '0)
                begin
                    idx_next   = job_reg.ec - CARD_W'(1);
                    state_next = S_ELO;
                end
                else
                begin
                    idx_next   = job_reg.pc;
                    state_next = S_PUP;
                end
            end
            S_ELO:
            begin
                // eta 1 just above a bound of -1 sits on the edge too
                if (cmp.eq_next || (eta_reg == SLOT_W'(1) && eta_slot == '1))
                begin
                    job_next.eta_edge = 1'b1;
                    job_next.ec_nb    = job_reg.ec - CARD_W'(1);
                end
                idx_next   = job_reg.pc;
                state_next = S_PUP;
            end
            S_PUP:
            begin
                if (cmp.eq)
                begin
                    job_next.phi_edge = 1'b1;
                    job_next.pc_nb    = (pc_inc == np) ? '0 : pc_inc[CARD_W-1:0];
                    state_next        = S_WAIT;
                end
                else if (job_reg.pc != '0)
                begin
                    idx_next   = job_reg.pc - CARD_W'(1);
                    state_next = S_PLO;
                end
                else
                begin
                    state_next = S_PWRAP;
                end
            end
            S_PLO:
            begin
                if (cmp.eq_next)
                begin
                    job_next.phi_edge = 1'b1;
                    job_next.pc_nb    = idx_reg;
                end
                state_next = S_WAIT;
            end
            S_PWRAP:
            begin
                // wrap from row 0 back to the last row
                if (cmp.eq_next && np > COUNT_W'(1))
                begin
                    job_next.phi_edge = 1'b1;
                    job_next.pc_nb    = np_last;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (emit_start)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        eta_reg   <= eta_next;
        phi_reg   <= phi_next;
        plast_reg <= plast_next;
        job_reg   <= job_next;
    end

    tcf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit_start),
        .job       (job_reg),
        .phi_cards (np),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `TCF_ASSERT_NOW(a_start_free, emit_start, !out_valid, "emit started while beat pending")
    `TCF_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready held after accept")
    `TCF_ASSERT_NOW(a_bad_single, out_valid && out_data.bad_input,
        out_data.last && out_data.card_index == '0, "bad beat not single zero beat")
    `TCF_ASSERT_NOW(a_eta_nb_differs, emit_start && job_reg.eta_edge && !job_reg.bad,
        job_reg.ec_nb != job_reg.ec, "eta neighbour equals home column")

endmodule
